FILE: hw/rtl/lccp_pkg.sv
// Shared types and constants for the lattice coefficient compress/pack block.
// No dependencies; used by every module under hw/rtl.
package lccp_pkg;

    localparam int COEFF_W       = 13;
    localparam int BITS_W        = 4;
    localparam int MAX_BITS      = 11;
    localparam int CODE_W        = MAX_BITS;
    localparam int REP_W         = 12;
    localparam int SCALED_W      = REP_W + MAX_BITS;
    localparam int BYTE_W        = 8;
    localparam int ACC_W         = BYTE_W - 1;
    localparam int CNT_W         = 3;
    localparam int WORD_W        = ACC_W + MAX_BITS;
    localparam int TOTAL_W       = 5;
    localparam int NUM_W         = 2;
    localparam int BUF_DEPTH     = 3;

    localparam logic signed [COEFF_W:0] MOD_Q      = 14'sd3329;
    localparam logic signed [COEFF_W:0] TWO_Q      = 14'sd6658;
    localparam logic signed [COEFF_W:0] NEG_Q      = -14'sd3329;
    localparam logic [SCALED_W-1:0]     HALF_Q     = 23'd1664;

    // ceil(2^35 / q): exact floor division by q for all dividends below 2^23
    localparam int                      RECIP_W     = 24;
    localparam logic [RECIP_W-1:0]      RECIP_Q     = 24'd10321340;
    localparam int                      RECIP_SHIFT = 35;
    localparam int                      PROD_W      = SCALED_W + RECIP_W;

    localparam logic [BITS_W-1:0]       RESET_BITS  = 4'd10;
    localparam logic [BITS_W-1:0]       MIN_BITS_V  = 4'd1;
    localparam logic [BITS_W-1:0]       MAX_BITS_V  = BITS_W'(MAX_BITS);

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [BITS_W-1:0] bits;
        logic              last;
    } lccp_item_t;

endpackage

FILE: hw/rtl/lccp_compress.sv
// Coefficient reduction mod q and rounding compression to d bits.
// Combinational; depends on lccp_pkg.
module lccp_compress (
    input  logic signed [lccp_pkg::COEFF_W-1:0] coefficient,
    input  logic        [lccp_pkg::BITS_W-1:0]  compress_bits,
    output logic        [lccp_pkg::CODE_W-1:0]  code,
    output logic        [lccp_pkg::BITS_W-1:0]  bits
);

    logic signed [lccp_pkg::COEFF_W:0]  coeff_ext;
    logic signed [lccp_pkg::COEFF_W:0]  rep_full;
    logic        [lccp_pkg::REP_W-1:0]  rep;
    logic        [lccp_pkg::SCALED_W-1:0] scaled;
    logic        [lccp_pkg::PROD_W-1:0] prod;
    logic        [lccp_pkg::CODE_W:0]   quot;
    logic        [lccp_pkg::CODE_W:0]   mask;

    always_comb begin
        if (compress_bits < lccp_pkg::MIN_BITS_V) begin
            bits = lccp_pkg::MIN_BITS_V;
        end else if (compress_bits > lccp_pkg::MAX_BITS_V) begin
            bits = lccp_pkg::MAX_BITS_V;
        end else begin
            bits = compress_bits;
        end
    end

    // bring the value into [0, q-1]
    always_comb begin
        coeff_ext = {coefficient[lccp_pkg::COEFF_W-1], coefficient};
        priority if (coeff_ext < lccp_pkg::NEG_Q) begin
            rep_full = coeff_ext + lccp_pkg::TWO_Q;
        end else if (coeff_ext < 14'sd0) begin
            rep_full = coeff_ext + lccp_pkg::MOD_Q;
        end else if (coeff_ext >= lccp_pkg::MOD_Q) begin
            rep_full = coeff_ext - lccp_pkg::MOD_Q;
        end else begin
            rep_full = coeff_ext;
        end
        rep = rep_full[lccp_pkg::REP_W-1:0];
    end

    // round(2^d * r / q) = floor((2^d * r + 1664) / q), via reciprocal multiply
    always_comb begin
        scaled = ({{lccp_pkg::MAX_BITS{1'b0}}, rep} << bits) + lccp_pkg::HALF_Q;
        prod   = {{lccp_pkg::RECIP_W{1'b0}}, scaled} *
                 {{lccp_pkg::SCALED_W{1'b0}}, lccp_pkg::RECIP_Q};
        quot   = prod[lccp_pkg::RECIP_SHIFT +: (lccp_pkg::CODE_W + 1)];
        mask   = ({{lccp_pkg::CODE_W{1'b0}}, 1'b1} << bits) - {{lccp_pkg::CODE_W{1'b0}}, 1'b1};
        code   = quot[lccp_pkg::CODE_W-1:0] & mask[lccp_pkg::CODE_W-1:0];
    end

endmodule

FILE: hw/rtl/lccp_packer.sv
// Bit accumulator and output byte buffer: packs codes LSB-first, emits bytes.
// Depends on lccp_pkg.
module lccp_packer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        item_valid,
    input  lccp_pkg::lccp_item_t        item,
    output logic                        item_take,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lccp_pkg::BYTE_W-1:0] m_packed_byte,
    output logic                        m_final_byte
);

    logic [lccp_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [lccp_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [lccp_pkg::NUM_W-1:0]   left_reg, left_next;
    logic                         last_reg, last_next;
    logic [lccp_pkg::BYTE_W-1:0]  byte_reg [lccp_pkg::BUF_DEPTH];
    logic [lccp_pkg::BYTE_W-1:0]  byte_next [lccp_pkg::BUF_DEPTH];

    logic [lccp_pkg::WORD_W-1:0]  word;
    logic [lccp_pkg::TOTAL_W-1:0] total;
    logic [lccp_pkg::NUM_W-1:0]   full_bytes;
    logic [lccp_pkg::NUM_W-1:0]   num_bytes;
    logic                         pop;

    assign m_valid       = (left_reg != '0);
    assign m_packed_byte = byte_reg[0];
    assign m_final_byte  = last_reg && (left_reg == 2'd1);
    assign pop           = m_valid && m_ready;
    // buffer drains its last pending byte this cycle, or is already empty
    assign item_take     = item_valid && ((left_reg == '0) || ((left_reg == 2'd1) && m_ready));

    always_comb begin
        word = {{lccp_pkg::MAX_BITS{1'b0}}, acc_reg} |
               ({{lccp_pkg::ACC_W{1'b0}}, item.code} << cnt_reg);
        total      = {2'b00, cnt_reg} + {1'b0, item.bits};
        full_bytes = total[lccp_pkg::TOTAL_W-1:lccp_pkg::CNT_W];
        num_bytes  = full_bytes +
                     {1'b0, (item.last && (total[lccp_pkg::CNT_W-1:0] != '0))};
    end

    always_comb begin
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        left_next = left_reg;
        last_next = last_reg;
        byte_next = byte_reg;
        if (item_take) begin
            byte_next[0] = word[7:0];
            byte_next[1] = word[15:8];
            byte_next[2] = {6'b0, word[17:16]};
            left_next    = num_bytes;
            last_next    = item.last;
            if (item.last) begin
                acc_next = '0;
                cnt_next = '0;
            end else begin
                cnt_next = total[lccp_pkg::CNT_W-1:0];
                unique case (full_bytes)
                    2'd0:    acc_next = word[6:0];
                    2'd1:    acc_next = word[14:8];
                    2'd2:    acc_next = {5'b0, word[17:16]};
                    default: acc_next = '0;
                endcase
            end
        end else if (pop) begin
            byte_next[0] = byte_reg[1];
            byte_next[1] = byte_reg[2];
            left_next    = left_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            cnt_reg  <= '0;
            left_reg <= '0;
            last_reg <= 1'b0;
        end else begin
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            left_reg <= left_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

endmodule

FILE: hw/rtl/lattice_coefficient_compress_pack.sv
// Coefficient compress and pack, top level. An accepted request goes from the input
// register through compression into the byte buffer, which raises m_valid if it
// yields a byte. Throughput: one request per cycle while each yields at most one
// byte and m_ready holds; otherwise one byte per cycle while m_ready holds, set by
// the single output byte port draining the three-entry byte buffer. Synchronous
// active-low reset empties the accumulator and buffers and sets compress_bits to 10.
// Depends on lccp_pkg, lccp_compress, lccp_packer.
module lattice_coefficient_compress_pack (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic        [lccp_pkg::BITS_W-1:0]    cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [lccp_pkg::COEFF_W-1:0]   s_coefficient,
    input  logic                                  s_final_coeff,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic        [lccp_pkg::BYTE_W-1:0]    m_packed_byte,
    output logic                                  m_final_byte
);

    logic        [lccp_pkg::BITS_W-1:0]  compress_bits_reg;
    logic                                in_vld_reg, in_vld_next;
    logic signed [lccp_pkg::COEFF_W-1:0] coeff_reg;
    logic                                final_reg;

    logic        [lccp_pkg::CODE_W-1:0]  item_code;
    logic        [lccp_pkg::BITS_W-1:0]  item_bits;
    lccp_pkg::lccp_item_t                item;
    logic                                item_take;

    assign s_ready = !in_vld_reg || item_take;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (item_take) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            compress_bits_reg <= lccp_pkg::RESET_BITS;
            in_vld_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                compress_bits_reg <= cfg_wr_data;
            end
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            coeff_reg <= s_coefficient;
            final_reg <= s_final_coeff;
        end
    end

    lccp_compress u_compress (
        .coefficient   (coeff_reg),
        .compress_bits (compress_bits_reg),
        .code          (item_code),
        .bits          (item_bits)
    );

    assign item = {item_code, item_bits, final_reg};

    lccp_packer u_packer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (in_vld_reg),
        .item          (item),
        .item_take     (item_take),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packed_byte (m_packed_byte),
        .m_final_byte  (m_final_byte)
    );

endmodule

FILE: tb/lattice_coefficient_compress_pack_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for lattice_coefficient_compress_pack: streams signed coefficients
// at several code widths and checks every packed byte against an in-bench model.
// Depends on lccp_pkg and the lattice_coefficient_compress_pack RTL.
module lattice_coefficient_compress_pack_tb;

    localparam int MODULUS   = 3329;
    localparam int ROUND_OFS = 1664;
    localparam int HOLD_AT   = 100;  // bytes seen before the long receiver hold
    localparam int HOLD_LEN  = 400;

    typedef struct {
        logic signed [lccp_pkg::COEFF_W-1:0] value;
        logic                                last;
    } coeff_req_t;

    typedef struct {
        logic [lccp_pkg::BYTE_W-1:0] data;
        logic                        last;
    } packed_byte_t;

    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 cfg_wr_en = 1'b0;
    logic        [lccp_pkg::BITS_W-1:0]   cfg_wr_data = '0;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    logic signed [lccp_pkg::COEFF_W-1:0]  s_coefficient = '0;
    logic                                 s_final_coeff = 1'b0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic        [lccp_pkg::BYTE_W-1:0]   m_packed_byte;
    logic                                 m_final_byte;

    coeff_req_t   coeff_q[$];
    packed_byte_t packed_q[$];

    // model state
    logic [lccp_pkg::BITS_W-1:0] width_cfg = lccp_pkg::RESET_BITS;
    int pend_bits = 0;
    int pend_count = 0;

    int  mismatches = 0;
    int  bytes_seen = 0;
    logic s_taken = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  hold_left = 0;
    logic hold_done = 1'b0;
    logic [7:0] rx_cycle = '0;

    lattice_coefficient_compress_pack u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_coefficient (s_coefficient),
        .s_final_coeff (s_final_coeff),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packed_byte (m_packed_byte),
        .m_final_byte  (m_final_byte)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    function automatic void predict_packed_bytes(logic signed [lccp_pkg::COEFF_W-1:0] coeff,
                                                 logic last);
        int width;
        int rep;
        int code;
        int n;
        logic [7:0] out_b[3];
        packed_byte_t rec;
        width = (width_cfg == 0) ? 1 :
                (width_cfg > lccp_pkg::MAX_BITS) ? lccp_pkg::MAX_BITS : int'(width_cfg);
        // full reduction so out-of-range inputs land in [0, q-1]
        rep = int'(coeff) % MODULUS;
        if (rep < 0) rep += MODULUS;
        code = (((rep << width) + ROUND_OFS) / MODULUS) & ((1 << width) - 1);
        pend_bits |= code << pend_count;
        pend_count += width;
        n = 0;
        while (pend_count >= 8) begin
            out_b[n] = pend_bits[7:0];
            pend_bits >>= 8;
            pend_count -= 8;
            n++;
        end
        if (last) begin
            if (pend_count > 0) begin
                out_b[n] = pend_bits[7:0];
                n++;
            end
            pend_bits = 0;
            pend_count = 0;
        end
        for (int i = 0; i < n; i++) begin
            rec.data = out_b[i];
            rec.last = last && (i == n - 1);
            packed_q.push_back(rec);
        end
    endfunction

    // acceptance tracking and prediction
    always @(posedge aclk) begin
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            predict_packed_bytes(s_coefficient, s_final_coeff);
    end

    // monitor
    always @(posedge aclk) begin : monitor
        packed_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            bytes_seen <= bytes_seen + 1;
            if (packed_q.size() == 0) begin
                report_mismatch("unexpected byte", int'(m_packed_byte), -1);
            end else begin
                want = packed_q.pop_front();
                if (m_packed_byte !== want.data)
                    report_mismatch("packed_byte", int'(m_packed_byte), int'(want.data));
                if (m_final_byte !== want.last)
                    report_mismatch("final_byte", int'(m_final_byte), int'(want.last));
            end
        end
    end

    // driver: bursts of requests with random gaps
    always @(negedge aclk) begin : sender
        coeff_req_t item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (coeff_q.size() != 0) begin
                item = coeff_q.pop_front();
                s_valid <= 1'b1;
                s_coefficient <= item.value;
                s_final_coeff <= item.last;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: rotating stall pattern plus one long hold
    always @(negedge aclk) begin : receiver
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 8'd1;
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else if (!hold_done && bytes_seen >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_LEN;
                m_ready <= 1'b0;
            end else begin
                case (rx_cycle[7:6])
                    2'd0: m_ready <= 1'b1;
                    2'd1: m_ready <= ($urandom_range(0, 3) != 0);
                    2'd2: m_ready <= ($urandom_range(0, 1) != 0);
                    default: m_ready <= rx_cycle[2];
                endcase
            end
        end
    end

    task automatic push_coeff(int v, logic last);
        coeff_req_t item;
        item.value = v[lccp_pkg::COEFF_W-1:0];
        item.last = last;
        coeff_q.push_back(item);
    endtask

    // all requests accepted, all bytes out, then waits for in-flight work
    task automatic wait_drained();
        while (coeff_q.size() != 0 || s_valid || packed_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_width(logic [lccp_pkg::BITS_W-1:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        width_cfg = v;
    endtask

    initial begin : stimulus
        int v;
        int poly_left;
        logic [lccp_pkg::BITS_W-1:0] w;
        poly_left = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset width, range extremes and out-of-range values, rounding edges
        push_coeff(-4096, 1'b0);
        push_coeff(4095, 1'b0);
        push_coeff(-3328, 1'b0);
        push_coeff(3328, 1'b0);
        push_coeff(0, 1'b0);
        push_coeff(-1, 1'b0);
        push_coeff(1, 1'b0);
        push_coeff(1664, 1'b0);
        push_coeff(1665, 1'b0);
        push_coeff(3329, 1'b0);
        push_coeff(-3329, 1'b0);
        push_coeff(3328, 1'b1);
        wait_drained();

        // widest code, left pending across the width change
        write_width(lccp_pkg::MAX_BITS_V);
        push_coeff(-1, 1'b0);
        push_coeff(3328, 1'b0);
        push_coeff(1665, 1'b0);
        wait_drained();

        // one-bit codes, partial byte flushed
        write_width(lccp_pkg::MIN_BITS_V);
        push_coeff(832, 1'b0);
        push_coeff(833, 1'b0);
        push_coeff(2496, 1'b0);
        push_coeff(2497, 1'b1);
        wait_drained();

        // out-of-range widths clamp to 1 and to the maximum
        write_width(4'd0);
        push_coeff(1665, 1'b0);
        push_coeff(-1664, 1'b0);
        wait_drained();
        write_width(4'd15);
        push_coeff(2000, 1'b0);
        push_coeff(-2000, 1'b1);

        for (int p = 0; p < 9; p++) begin
            wait_drained();
            case (p)
                0: w = 4'd4;
                1: w = 4'd5;
                2: w = 4'd11;
                3: w = 4'd1;
                4: w = 4'd0;
                5: w = 4'd15;
                6: w = 4'd10;
                default: w = lccp_pkg::BITS_W'($urandom_range(0, 15));
            endcase
            write_width(w);
            // mostly whole polynomials; a phase may end mid-polynomial
            for (int i = 0; i < 45; i++) begin
                if (poly_left == 0) poly_left = $urandom_range(1, 24);
                poly_left--;
                if ($urandom_range(0, 7) == 0) v = $urandom;
                else v = $urandom_range(0, 2 * 3328) - 3328;
                push_coeff(v, poly_left == 0);
            end
        end

        wait_drained();
        if (mismatches == 0 && packed_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
